@@ sv/sql_injection_signature_scan_unit_macros.svh @@
// ----------------------------------------------------------------------------
// sql injection signature scan unit - assertion macros
// clocked assertion helpers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef SQL_INJECTION_SIGNATURE_SCAN_UNIT_MACROS_SVH
`define SQL_INJECTION_SIGNATURE_SCAN_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`ifndef SYNTH
`define SQLSS_ASSERT_NOW(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);
`else
`define SQLSS_ASSERT_NOW(name, pre, post, msg)
`endif

// next-cycle implication, sampled on clk, off during reset
`ifndef SYNTH
`define SQLSS_ASSERT_NEXT(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define SQLSS_ASSERT_NEXT(name, pre, post, msg)
`endif

`endif

@@ sv/sqlss_pkg.sv @@
// ----------------------------------------------------------------------------
// sqlss_pkg
// beat types, register indexes and reset values of the signature scan unit
// ----------------------------------------------------------------------------
package sqlss_pkg;

    localparam int PATTERN_COUNT = 7;
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 7;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_ENABLE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_REQUIRE_METHOD = 2'd1;

    localparam logic [PATTERN_COUNT-1:0] PATTERN_ENABLE_RESET = 7'h7f;
    localparam logic                     REQUIRE_METHOD_RESET = 1'b1;

    // signature bit positions
    localparam int SIG_UNION    = 0;
    localparam int SIG_STACKED  = 1;
    localparam int SIG_COMMENT  = 2;
    localparam int SIG_EQUALS   = 3;
    localparam int SIG_ORDER_BY = 4;
    localparam int SIG_WAITFOR  = 5;
    localparam int SIG_ASCII    = 6;

    typedef struct packed {
        logic [7:0] line_byte;
        logic       line_end;
    } item_t;

    typedef struct packed {
        logic union_found;
        logic stacked_found;
        logic comment_found;
        logic equals_found;
        logic order_by_found;
        logic waitfor_found;
        logic ascii_found;
        logic method_found;
        logic alarm;
    } result_t;

endpackage

@@ sv/sql_injection_signature_scan_unit.sv @@
// ----------------------------------------------------------------------------
// sql_injection_signature_scan_unit
// scans log lines one byte per beat for seven sql injection signatures
// ----------------------------------------------------------------------------
// timing: an accepted byte is scanned from the single registered scan stage;
//   a line's result beat is valid right after the edge that scans its last byte
// throughput: one byte per cycle unless a last byte waits on a full result
// reset: rst_n asynchronous active low; clears beat valids and all line state,
//   pattern_enable to 7'h7f and require_method to 1
// ----------------------------------------------------------------------------
`include "sql_injection_signature_scan_unit_macros.svh"

module sql_injection_signature_scan_unit
    import sqlss_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // byte beats
    input  logic                   item_valid,
    output logic                   item_ready,
    input  item_t                  item,
    // per-line result beats
    output logic                   result_valid,
    input  logic                   result_ready,
    output result_t                result,
    // configuration writes
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_NEWLINE = 8'h0a;
    localparam logic [7:0] CH_QUOTE   = 8'h27;

    // fold a letter to lower case, other bytes fold onto a partner value only
    function automatic logic [7:0] fold(input logic [7:0] b);
        return b | 8'h20;
    endfunction

    // configuration
    logic [PATTERN_COUNT-1:0] pattern_enable_reg;
    logic                     require_method_reg;

    // input stage
    logic  stage_valid_reg, stage_valid_next;
    item_t stage_reg;

    // line state
    logic [55:0]              recent_reg, recent_next;
    logic                     opener_reg, opener_next;
    logic [1:0]               order_gap_reg, order_gap_next;
    logic [1:0]               waitfor_gap_reg, waitfor_gap_next;
    logic [PATTERN_COUNT-1:0] hit_reg, hit_next;
    logic                     method_reg, method_next;
    logic                     stopped_reg, stopped_next;

    // result stage
    logic    result_valid_reg, result_valid_next;
    result_t result_reg, result_next;

    logic                     advance;
    logic                     take;
    logic [7:0]               win [8];
    logic [PATTERN_COUNT-1:0] hit_now;
    logic                     sep_now, order_end, waitfor_end, armed, method_now;
    logic [PATTERN_COUNT-1:0] flags_line;
    logic                     method_line;

    // --------------------------------------------------------------------
    // handshake: the stage moves on unless a last byte finds the result
    // register full and not being drained
    // --------------------------------------------------------------------
    assign advance    = stage_valid_reg &&
                        (!stage_reg.line_end || !result_valid_reg || result_ready);
    assign item_ready = !stage_valid_reg || advance;

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // a zero byte and everything after it are ignored until line end
    assign take = !stopped_reg && (stage_reg.line_byte != CH_NUL);

    // byte window: win[0] is the byte being scanned, win[k] k bytes older
    always_comb
    begin
        win[0] = stage_reg.line_byte;
        for (int k = 1; k < 8; k++)
        begin
            win[k] = recent_reg[8*(k-1) +: 8];
        end
    end

    // --------------------------------------------------------------------
    // signature compares on the window
    // --------------------------------------------------------------------
    always_comb
    begin
        sep_now     = ({win[2], win[1], win[0]} == "%27") ||
                      ({win[2], win[1], win[0]} == "%20");
        order_end   = {fold(win[4]), fold(win[3]), fold(win[2]), fold(win[1]),
                       fold(win[0])} == "order";
        waitfor_end = {fold(win[6]), fold(win[5]), fold(win[4]), fold(win[3]),
                       fold(win[2]), fold(win[1]), fold(win[0])} == "waitfor";
        // separator only re-arms when it directly follows the previous end
        armed       = order_end || (sep_now && order_gap_reg == 2'd2);
        method_now  = ({win[2], win[1], win[0]} == "GET") ||
                      ({win[3], win[2], win[1], win[0]} == "POST");

        hit_now = '0;
        hit_now[SIG_UNION] = {fold(win[4]), fold(win[3]), fold(win[2]), fold(win[1]),
                              fold(win[0])} == "union";
        hit_now[SIG_STACKED] = (win[0] == ";") ||
                               ({win[2], win[1], win[0]} == "%3B");
        hit_now[SIG_COMMENT] = (win[0] == "#") ||
                               ({win[2], win[1], win[0]} == "%23") ||
                               ({win[5], win[4], win[3], win[2], win[1], win[0]}
                                    == "%2D%2D") ||
                               ({win[1], win[0]} == "--") ||
                               ({win[5], win[4], win[3], win[2], win[1], win[0]}
                                    == "%2F%2A") ||
                               ({win[1], win[0]} == "/*");
        hit_now[SIG_EQUALS] = opener_reg &&
                              ((win[0] == "=") || ({win[2], win[1], win[0]} == "%3D"));
        // "by" right after a separator that ended on the byte before "b"
        hit_now[SIG_ORDER_BY] = (fold(win[0]) == "y") && (fold(win[1]) == "b") &&
                                (order_gap_reg == 2'd1) &&
                                ((win[2] == "0") || (win[2] == "7"));
        hit_now[SIG_WAITFOR] = sep_now && (waitfor_gap_reg == 2'd2);
        hit_now[SIG_ASCII] = {fold(win[4]), fold(win[3]), fold(win[2]), fold(win[1]),
                              fold(win[0])} == "ascii";
    end

    // flags of the line including the byte in the stage
    assign flags_line  = take ? (hit_reg | hit_now) : hit_reg;
    assign method_line = take ? (method_reg | method_now) : method_reg;

    // --------------------------------------------------------------------
    // line state update
    // --------------------------------------------------------------------
    always_comb
    begin
        recent_next      = recent_reg;
        opener_next      = opener_reg;
        order_gap_next   = order_gap_reg;
        waitfor_gap_next = waitfor_gap_reg;
        hit_next         = hit_reg;
        method_next      = method_reg;
        stopped_next     = stopped_reg;

        if (advance)
        begin
            if (!stopped_reg && stage_reg.line_byte == CH_NUL)
            begin
                stopped_next = 1'b1;
            end

            if (take)
            begin
                recent_next = {recent_reg[47:0], stage_reg.line_byte};
                hit_next    = flags_line;
                method_next = method_line;

                if (armed)
                    order_gap_next = 2'd0;
                else if (order_gap_reg != 2'd3)
                    order_gap_next = order_gap_reg + 2'd1;

                if (waitfor_end)
                    waitfor_gap_next = 2'd0;
                else if (waitfor_gap_reg != 2'd3)
                    waitfor_gap_next = waitfor_gap_reg + 2'd1;

                // newline cancels an opener, a quote or separator sets it
                if (stage_reg.line_byte == CH_NEWLINE)
                    opener_next = 1'b0;
                else if (stage_reg.line_byte == CH_QUOTE || sep_now)
                    opener_next = 1'b1;
            end

            // last byte: start the next line from scratch
            if (stage_reg.line_end)
            begin
                recent_next      = '0;
                opener_next      = 1'b0;
                order_gap_next   = 2'd3;
                waitfor_gap_next = 2'd3;
                hit_next         = '0;
                method_next      = 1'b0;
                stopped_next     = 1'b0;
            end
        end
    end

    // --------------------------------------------------------------------
    // result register
    // --------------------------------------------------------------------
    always_comb
    begin
        result_next.union_found    = flags_line[SIG_UNION];
        result_next.stacked_found  = flags_line[SIG_STACKED];
        result_next.comment_found  = flags_line[SIG_COMMENT];
        result_next.equals_found   = flags_line[SIG_EQUALS];
        result_next.order_by_found = flags_line[SIG_ORDER_BY];
        result_next.waitfor_found  = flags_line[SIG_WAITFOR];
        result_next.ascii_found    = flags_line[SIG_ASCII];
        result_next.method_found   = method_line;
        // enables only gate the alarm, never the flags
        result_next.alarm          = (|(flags_line & pattern_enable_reg)) &&
                                     (!require_method_reg || method_line);

        if (advance && stage_reg.line_end)
            result_valid_next = 1'b1;
        else if (result_ready)
            result_valid_next = 1'b0;
        else
            result_valid_next = result_valid_reg;
    end

    assign stage_valid_next = item_ready ? item_valid : stage_valid_reg;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_enable_reg <= PATTERN_ENABLE_RESET;
            require_method_reg <= REQUIRE_METHOD_RESET;
            stage_valid_reg    <= 1'b0;
            result_valid_reg   <= 1'b0;
            recent_reg         <= '0;
            opener_reg         <= 1'b0;
            order_gap_reg      <= 2'd3;
            waitfor_gap_reg    <= 2'd3;
            hit_reg            <= '0;
            method_reg         <= 1'b0;
            stopped_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_PATTERN_ENABLE: pattern_enable_reg <= cfg_data[PATTERN_COUNT-1:0];
                    CFG_REQUIRE_METHOD: require_method_reg <= cfg_data[0];
                    default:            ;
                endcase
            end
            stage_valid_reg  <= stage_valid_next;
            result_valid_reg <= result_valid_next;
            recent_reg       <= recent_next;
            opener_reg       <= opener_next;
            order_gap_reg    <= order_gap_next;
            waitfor_gap_reg  <= waitfor_gap_next;
            hit_reg          <= hit_next;
            method_reg       <= method_next;
            stopped_reg      <= stopped_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
            stage_reg <= item;
        if (advance && stage_reg.line_end)
            result_reg <= result_next;
    end

    // --------------------------------------------------------------------
    // assertions
    // --------------------------------------------------------------------
    `SQLSS_ASSERT_NEXT(a_line_end_gives_result, advance && stage_reg.line_end,
        result_valid_reg, "scanned last byte gave no result beat")
    `SQLSS_ASSERT_NEXT(a_line_state_cleared, advance && stage_reg.line_end,
        hit_reg == '0 && !method_reg && !stopped_reg && !opener_reg,
        "line state not cleared after line end")
    `SQLSS_ASSERT_NOW(a_alarm_needs_flag, result_valid_reg && result_reg.alarm,
        result_reg.union_found || result_reg.stacked_found || result_reg.comment_found ||
        result_reg.equals_found || result_reg.order_by_found ||
        result_reg.waitfor_found || result_reg.ascii_found,
        "alarm without any signature flag")
    `SQLSS_ASSERT_NEXT(a_stalled_stage_kept, stage_valid_reg && !advance,
        stage_valid_reg && $stable(stage_reg), "stalled byte lost from stage")

endmodule

@@ bench/tb_sql_injection_signature_scan_unit.sv @@
// ----------------------------------------------------------------------------
// tb_sql_injection_signature_scan_unit
// self-checking bench: log lines go in one byte per beat, every per-line
// verdict is checked field by field against a bit-level scan predictor or,
// for some directed lines, a written verdict; directed lines first, then random lines in several register settings
// ----------------------------------------------------------------------------
module tb_sql_injection_signature_scan_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import sqlss_pkg::*;

    localparam int CYCLE_NS       = 10;
    localparam int RESET_CYCLES   = 10;
    localparam int SETTLE_CYCLES  = 6;      // margin for the scan stage to drain
    localparam int MAX_GAP        = 17;
    localparam int RANDOM_BYTES   = 300;
    localparam int RANDOM_PHASES  = 6;
    localparam int PRESSURE_PHASE = 2;
    localparam int LONG_HOLD      = 300;
    localparam int MAX_REPORTS    = 10;
    localparam int NO_ZERO        = -1;
    localparam int TIMEOUT_CYCLES = 200_000;

    typedef logic [7:0] byte_q_t [$];

    // one directed line, optionally preceded by a register setting
    typedef struct {
        bit                       set_cfg;
        logic [PATTERN_COUNT-1:0] pe;
        logic                     rm;
        string                    text;
        int                       zero_at;
        bit                       typed;
        result_t                  want;
    } line_row_t;

    // ------------------------------------------------------------------------
    // dut signals, inputs known from time zero
    // ------------------------------------------------------------------------
    logic                   clk          = 1'b0;
    logic                   rst_n        = 1'b0;
    logic                   item_valid   = 1'b0;
    logic                   item_ready;
    item_t                  item         = '0;
    logic                   result_valid;
    logic                   result_ready = 1'b0;
    result_t                result;
    logic                   cfg_write    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index    = '0;
    logic [CFG_DATA_W-1:0]  cfg_data     = '0;

    sql_injection_signature_scan_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #(CYCLE_NS / 2) clk = ~clk;

    // ------------------------------------------------------------------------
    // scan predictor state: registers and per-line match state
    // ------------------------------------------------------------------------
    logic [PATTERN_COUNT-1:0] pat_en   = PATTERN_ENABLE_RESET;
    logic                     req_meth = REQUIRE_METHOD_RESET;
    logic [55:0]              hist     = '0;     // last seven bytes, newest low
    logic                     opener   = 1'b0;   // quote or separator since newline
    logic [1:0]               ord_gap  = 2'd3;   // bytes since order or separator end
    logic [1:0]               wait_gap = 2'd3;   // bytes since waitfor end
    logic [PATTERN_COUNT-1:0] hits     = '0;
    logic                     meth_seen = 1'b0;
    logic                     stopped  = 1'b0;   // zero byte seen, rest of line dead
    logic [7:0]               win [8];           // win[0] current byte, win[k] k back

    result_t   verdict_q [$];      // line verdicts still owed by the dut
    line_row_t row_q [$];
    int        mismatch_count   = 0;
    int        sink_hold_cycles = 0;

    string flag_name [$bits(result_t)] = '{"alarm", "method_found", "ascii_found",
        "waitfor_found", "order_by_found", "equals_found", "comment_found",
        "stacked_found", "union_found"};

    // signature fragments for random lines; letters not in a %xx code get mixed case
    string sig_tokens [$] = '{"union", "order", "by", "waitfor", "ascii", "select",
        "%27", "%20", "%3B", "%23", "%2D%2D", "%2F%2A", "%3D", "%2D", "%2F", "%2",
        ";", "#", "--", "/*", "'", "=", "\n", " ", "-", "/", "*",
        "order%20by", "ORDER%27%20BY", "order%20%27%20by", "waitfor%27", "WAITFOR%20",
        "'%20or%201=1", "%27%3D", "union%20select", "ascii(",
        "unio", "orde%2", "waitfo%27", "asci", "order%20x", "waitfor%2"};

    // method words are case sensitive, so they go in as written
    string method_tokens [$] = '{"GET ", "POST ", "GET", "POST", "get ", "Post ", "PUT "};

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    // true when the window ends with pat, oldest char first; fold ignores case
    function automatic bit tail_is(string pat, bit fold);
        logic [7:0] b;
        for (int i = 0; i < pat.len(); i++)
        begin
            b = win[pat.len() - 1 - i];
            if (fold)
                b = b | 8'h20;
            if (b != 8'(pat[i]))
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void clear_line();
        hist      = '0;
        opener    = 1'b0;
        ord_gap   = 2'd3;
        wait_gap  = 2'd3;
        hits      = '0;
        meth_seen = 1'b0;
        stopped   = 1'b0;
    endfunction

    function automatic void scan_byte(logic [7:0] c);
        logic [PATTERN_COUNT-1:0] h;
        bit                       sep_now;
        bit                       armed;
        h = '0;
        win[0] = c;
        for (int k = 1; k < 8; k++)
            win[k] = hist[8 * (k - 1) +: 8];

        if (tail_is("union", 1'b1))
            h[SIG_UNION] = 1'b1;
        if (c == ";" || tail_is("%3B", 1'b0))
            h[SIG_STACKED] = 1'b1;
        if (c == "#" || tail_is("%23", 1'b0) || tail_is("%2D%2D", 1'b0) ||
            tail_is("--", 1'b0) || tail_is("%2F%2A", 1'b0) || tail_is("/*", 1'b0))
            h[SIG_COMMENT] = 1'b1;
        if (opener && (c == "=" || tail_is("%3D", 1'b0)))
            h[SIG_EQUALS] = 1'b1;

        // "by" right after a separator that ended on the byte before "b"
        if ((c | 8'h20) == "y" && (win[1] | 8'h20) == "b" && ord_gap == 2'd1 &&
            (win[2] == "0" || win[2] == "7"))
            h[SIG_ORDER_BY] = 1'b1;
        sep_now = tail_is("%27", 1'b0) || tail_is("%20", 1'b0);
        armed   = tail_is("order", 1'b1) || (sep_now && ord_gap == 2'd2);
        if (armed)
            ord_gap = 2'd0;
        else if (ord_gap != 2'd3)
            ord_gap = ord_gap + 2'd1;

        if (sep_now && wait_gap == 2'd2)
            h[SIG_WAITFOR] = 1'b1;
        if (tail_is("waitfor", 1'b1))
            wait_gap = 2'd0;
        else if (wait_gap != 2'd3)
            wait_gap = wait_gap + 2'd1;

        if (tail_is("ascii", 1'b1))
            h[SIG_ASCII] = 1'b1;
        if (tail_is("GET", 1'b0) || tail_is("POST", 1'b0))
            meth_seen = 1'b1;

        if (c == "\n")
            opener = 1'b0;
        else if (c == "'" || sep_now)
            opener = 1'b1;

        hits = hits | h;
        hist = {hist[47:0], c};
    endfunction

    function automatic result_t pack_verdict(logic [PATTERN_COUNT-1:0] sig, logic meth,
                                             logic al);
        result_t v;
        v.union_found    = sig[SIG_UNION];
        v.stacked_found  = sig[SIG_STACKED];
        v.comment_found  = sig[SIG_COMMENT];
        v.equals_found   = sig[SIG_EQUALS];
        v.order_by_found = sig[SIG_ORDER_BY];
        v.waitfor_found  = sig[SIG_WAITFOR];
        v.ascii_found    = sig[SIG_ASCII];
        v.method_found   = meth;
        v.alarm          = al;
        return v;
    endfunction

    // advance the predictor by one accepted beat; true when a verdict is due
    function automatic bit line_step(input item_t beat, output result_t verdict);
        verdict = '0;
        if (!stopped)
        begin
            if (beat.line_byte == 8'h00)
                stopped = 1'b1;
            else
                scan_byte(beat.line_byte);
        end
        if (!beat.line_end)
            return 1'b0;
        verdict = pack_verdict(hits, meth_seen,
                               ((hits & pat_en) != '0) && (!req_meth || meth_seen));
        clear_line();
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // line building
    // ------------------------------------------------------------------------
    function automatic void add_token(ref byte_q_t q, input string tok, input bit mix);
        logic [7:0] ch;
        bit         in_code;
        for (int i = 0; i < tok.len(); i++)
        begin
            ch      = tok[i];
            in_code = (i >= 1 && tok[i - 1] == "%") || (i >= 2 && tok[i - 2] == "%");
            if (mix && !in_code && (ch | 8'h20) >= "a" && (ch | 8'h20) <= "z" &&
                $urandom_range(0, 1) == 1)
                ch = ch ^ 8'h20;
            q.push_back(ch);
        end
    endfunction

    // mostly signature fragments, some raw bytes and the odd zero byte
    function automatic byte_q_t build_line(bit brief);
        byte_q_t q;
        int      ntok;
        int      pick;
        ntok = brief ? $urandom_range(1, 2) : $urandom_range(1, 6);
        if (!brief && $urandom_range(0, 3) != 0)
            add_token(q, method_tokens[$urandom_range(0, method_tokens.size() - 1)], 1'b0);
        for (int t = 0; t < ntok; t++)
        begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
                q.push_back(8'($urandom_range(1, 255)));
            else if (pick == 1 && $urandom_range(0, 3) == 0)
                q.push_back(8'h00);
            else
                add_token(q, sig_tokens[$urandom_range(0, sig_tokens.size() - 1)], 1'b1);
        end
        if (q.size() == 0)
            q.push_back(8'($urandom_range(0, 255)));
        return q;
    endfunction

    function automatic void add_row(bit set_cfg, logic [PATTERN_COUNT-1:0] pe, logic rm,
                                    string text, int zero_at, bit typed, result_t want);
        line_row_t r;
        r.set_cfg = set_cfg;
        r.pe      = pe;
        r.rm      = rm;
        r.text    = text;
        r.zero_at = zero_at;
        r.typed   = typed;
        r.want    = want;
        row_q.push_back(r);
    endfunction

    // ------------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------------
    function automatic void note_fault(string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%s", msg);
    endfunction

    function automatic void check_result(result_t got);
        result_t                    want;
        logic [$bits(result_t)-1:0] w;
        logic [$bits(result_t)-1:0] g;
        if (verdict_q.size() == 0)
        begin
            note_fault($sformatf("result beat with no line pending: %b", got));
            return;
        end
        want = verdict_q.pop_front();
        w    = want;
        g    = got;
        for (int i = $bits(result_t) - 1; i >= 0; i--)
            if (w[i] !== g[i])
                note_fault($sformatf("%s: expected %b, got %b", flag_name[i], w[i], g[i]));
    endfunction

    // ------------------------------------------------------------------------
    // byte side driving
    // ------------------------------------------------------------------------

    // called right after an edge; valid stays up across back-to-back beats
    task automatic offer_byte(logic [7:0] c, bit last, int gap, bit typed, result_t want);
        item_t   beat;
        result_t verdict;
        beat.line_byte = c;
        beat.line_end  = last;
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= beat;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        // beat taken at this edge
        if (line_step(beat, verdict))
            verdict_q.push_back(typed ? want : verdict);
    endtask

    task automatic send_line(byte_q_t bytes, bit burst, bit typed, result_t want);
        for (int i = 0; i < bytes.size(); i++)
            offer_byte(bytes[i], i == bytes.size() - 1,
                       burst ? 0 : $urandom_range(0, MAX_GAP), typed, want);
    endtask

    // wait for every owed verdict, then let the scan stage drain
    task automatic settle();
        item_valid <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        if (idx == CFG_PATTERN_ENABLE)
            pat_en = val[PATTERN_COUNT-1:0];
        else if (idx == CFG_REQUIRE_METHOD)
            req_meth = val[0];
    endtask

    // both registers, plus junk into the unused indexes which must be dropped
    task automatic set_config(logic [PATTERN_COUNT-1:0] pe, logic rm);
        logic [CFG_DATA_W-1:0] val;
        settle();
        val = CFG_DATA_W'($urandom);
        val[PATTERN_COUNT-1:0] = pe;
        write_reg(CFG_PATTERN_ENABLE, val);
        val    = CFG_DATA_W'($urandom);
        val[0] = rm;
        write_reg(CFG_REQUIRE_METHOD, val);
        for (int i = CFG_REQUIRE_METHOD + 1; i < (1 << CFG_INDEX_W); i++)
            write_reg(CFG_INDEX_W'(i), CFG_DATA_W'($urandom));
    endtask

    // ------------------------------------------------------------------------
    // result side: random stalls, bursts of always-ready, one long hold-off
    // ------------------------------------------------------------------------
    initial
    begin : result_sink
        int stall;
        int burst_left;
        burst_left = 0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (sink_hold_cycles > 0)
            begin
                // long hold so the dut backs up and stalls its byte side
                stall            = sink_hold_cycles;
                sink_hold_cycles = 0;
            end
            else
            begin
                if (burst_left == 0 && $urandom_range(0, 7) == 0)
                    burst_left = $urandom_range(4, 20);
                if (burst_left > 0)
                begin
                    burst_left--;
                    stall = 0;
                end
                else
                    stall = $urandom_range(0, MAX_GAP);
            end
            if (stall > 0)
            begin
                result_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ready <= 1'b1;
            @(posedge clk);
            while (!result_valid)
                @(posedge clk);
            check_result(result);
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial
    begin : byte_source
        byte_q_t                  line;
        logic [PATTERN_COUNT-1:0] pe;
        logic                     rm;
        int                       sent;
        bit                       pressure;

        clear_line();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed lines, reset register values first
        add_row(1'b0, '0, 1'b0, "GET x", NO_ZERO, 1'b1, pack_verdict('0, 1'b1, 1'b0));
        add_row(1'b0, '0, 1'b0, "GET union", NO_ZERO, 1'b1,
                pack_verdict(7'(1 << SIG_UNION), 1'b1, 1'b1));
        // signature without a method: flagged, no alarm
        add_row(1'b0, '0, 1'b0, "union", NO_ZERO, 1'b1,
                pack_verdict(7'(1 << SIG_UNION), 1'b0, 1'b0));
        add_row(1'b0, '0, 1'b0, "POST UnIoN", NO_ZERO, 1'b0, '0);
        add_row(1'b0, '0, 1'b0, "GET a;b", NO_ZERO, 1'b0, '0);
        add_row(1'b0, '0, 1'b0, "GET %3B", NO_ZERO, 1'b0, '0);
        add_row(1'b0, '0, 1'b0, "GET %23", NO_ZERO, 1'b0, '0);
        add_row(1'b0, '0, 1'b0, "POST %2D%2D", NO_ZERO, 1'b0, '0);
        add_row(1'b0, '0, 1'b0, "GET --", NO_ZERO, 1'b0, '0);
        add_row(1'b0, '0, 1'b0, "GET %2F%2A", NO_ZERO, 1'b0, '0);
        add_row(1'b0, '0, 1'b0, "GET /*#", NO_ZERO, 1'b0, '0);
        add_row(1'b0, '0, 1'b0, "GET 'x=1", NO_ZERO, 1'b0, '0);
        add_row(1'b0, '0, 1'b0, "GET %27a%3D", NO_ZERO, 1'b0, '0);
        // newline between opener and equals cancels the opener
        add_row(1'b0, '0, 1'b0, "GET '\n=", NO_ZERO, 1'b0, '0);
        add_row(1'b0, '0, 1'b0, "GET ORDER%20%27BY", NO_ZERO, 1'b0, '0);
        add_row(1'b0, '0, 1'b0, "GET order by", NO_ZERO, 1'b0, '0);
        add_row(1'b0, '0, 1'b0, "GET WAITFOR%27", NO_ZERO, 1'b0, '0);
        add_row(1'b0, '0, 1'b0, "GET AsCiI", NO_ZERO, 1'b0, '0);
        add_row(1'b0, '0, 1'b0, "get union", NO_ZERO, 1'b0, '0);
        // zero byte kills the rest of the line
        add_row(1'b0, '0, 1'b0, "GET union", 4, 1'b1, pack_verdict('0, 1'b1, 1'b0));
        add_row(1'b0, '0, 1'b0, "", 0, 1'b1, pack_verdict('0, 1'b0, 1'b0));
        add_row(1'b0, '0, 1'b0, "\377", NO_ZERO, 1'b1, pack_verdict('0, 1'b0, 1'b0));
        // flags report regardless of enables, alarm is gated
        add_row(1'b1, '0, 1'b1, "GET union;", NO_ZERO, 1'b1,
                pack_verdict(7'((1 << SIG_UNION) | (1 << SIG_STACKED)), 1'b1, 1'b0));
        add_row(1'b1, PATTERN_ENABLE_RESET, 1'b0, "union", NO_ZERO, 1'b1,
                pack_verdict(7'(1 << SIG_UNION), 1'b0, 1'b1));
        add_row(1'b1, 7'(1 << SIG_ASCII), 1'b0, "ascii union", NO_ZERO, 1'b0, '0);

        foreach (row_q[r])
        begin
            if (row_q[r].set_cfg)
                set_config(row_q[r].pe, row_q[r].rm);
            line.delete();
            for (int i = 0; i < row_q[r].text.len(); i++)
            begin
                if (i == row_q[r].zero_at)
                    line.push_back(8'h00);
                line.push_back(row_q[r].text[i]);
            end
            if (row_q[r].zero_at == row_q[r].text.len())
                line.push_back(8'h00);
            send_line(line, $urandom_range(0, 3) == 0, row_q[r].typed, row_q[r].want);
        end

        // random lines across several register settings
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph)
                0:       begin pe = PATTERN_ENABLE_RESET; rm = 1'b1; end
                1:       begin pe = '0; rm = 1'b0; end
                2:       begin pe = PATTERN_COUNT'($urandom); rm = 1'b0; end
                3:       begin pe = PATTERN_COUNT'($urandom); rm = 1'b1; end
                4:       begin pe = PATTERN_ENABLE_RESET; rm = 1'b0; end
                default: begin pe = PATTERN_COUNT'($urandom); rm = 1'($urandom); end
            endcase
            set_config(pe, rm);
            // pressure phase: short lines back to back while the sink holds off
            pressure = (ph == PRESSURE_PHASE);
            if (pressure)
                sink_hold_cycles = LONG_HOLD;
            sent = 0;
            while (sent < RANDOM_BYTES / RANDOM_PHASES)
            begin
                line = build_line(pressure);
                send_line(line, pressure || $urandom_range(0, 3) == 0, 1'b0, '0);
                sent += line.size();
            end
        end

        settle();
        if (mismatch_count == 0 && verdict_q.size() == 0)
            $display("sql_injection_signature_scan_unit: match");
        else
            $display("sql_injection_signature_scan_unit: mismatch");
        $finish;
    end

    // hang guard
    initial
    begin
        #(CYCLE_NS * TIMEOUT_CYCLES);
        $display("sql_injection_signature_scan_unit: mismatch");
        $finish;
    end

endmodule

@@ sql_injection_signature_scan_unit.f @@
+incdir+sv
sv/sqlss_pkg.sv
sv/sql_injection_signature_scan_unit.sv
bench/tb_sql_injection_signature_scan_unit.sv
